// File: rtl/trr_pkg.sv
// Shared types and constants for the triangle tile rasterizer.
package trr_pkg;

	localparam int CW   = 14;  // vertex coordinate width
	localparam int DW   = 15;  // vertex difference width
	localparam int BW   = 15;  // bounding box / pixel walker width
	localparam int EW   = 32;  // edge function width
	localparam int DABW = 30;  // magnitude of determinant
	localparam int LIMW = 46;  // wire_width * |det|
	localparam int PW   = 48;  // shared multiplier product
	localparam int RW   = 38;  // divider remainder
	localparam int QDEPTH = 2;

	localparam int IN_W  = 128;
	localparam int OUT_W = 48;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] CFG_SHADE_MODE    = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_FACE_CULL     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_WIRE_WIDTH    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 3'd4;

	typedef enum logic [1:0] {
		DRAW_FLAT = 2'd0,
		DRAW_BARY = 2'd1,
		DRAW_WIRE = 2'd2
	} shade_mode_t;

	typedef enum logic [1:0] {
		CULL_NONE = 2'd0,
		CULL_POS  = 2'd1,
		CULL_NEG  = 2'd2
	} face_cull_t;

	// Triangle setup record handed from front to back.
	typedef struct packed {
		logic                   empty;
		logic signed [DW-1:0]   dx0;
		logic signed [DW-1:0]   dx1;
		logic signed [DW-1:0]   dx2;
		logic signed [DW-1:0]   dy0;
		logic signed [DW-1:0]   dy1;
		logic signed [DW-1:0]   dy2;
		logic signed [EW-1:0]   e0;
		logic signed [EW-1:0]   e1;
		logic signed [EW-1:0]   e2;
		logic [DABW-1:0]        dabs;
		logic [LIMW-1:0]        lim;
		logic signed [BW-1:0]   lx;
		logic signed [BW-1:0]   hx;
		logic signed [BW-1:0]   ly;
		logic signed [BW-1:0]   hy;
		logic [7:0]             red;
		logic [7:0]             green;
		logic [7:0]             blue;
	} tri_rec_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DET0,
		F_DET1,
		F_SETUP,
		F_EDGE,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EVAL,
		B_DIV,
		B_EMIT,
		B_END
	} back_state_t;

endpackage

// File: rtl/triangle_tile_rasterizer.sv
// Top level: configuration registers, triangle setup, record queue and pixel walker.
// Setup runs on one shared multiplier and skips the edge values for a culled or off-tile
// triangle. The walker visits one box pixel per cycle while it rejects pixels; a kept
// pixel goes through the emit state, which can stall on the output, and in barycentric
// mode first through the 8-step divider on three lanes. arst_n clears control state and
// sets register defaults.
module triangle_tile_rasterizer #(
	parameter int TILE_SIDE  = 8,
	parameter int SCREEN_MAX = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// ax, ay, bx, by_, cx, cy, flat_red, flat_green, flat_blue, tile_col, tile_row
	input  logic [trr_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// pixel_x, pixel_y, out_red, out_green, out_blue
	output logic [trr_pkg::OUT_W-1:0]     m_axis_tdata,
	// covered
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [trr_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [trr_pkg::CFG_DW-1:0]    cfg_data
);

	logic [1:0]  shade_mode_q, face_cull_q;
	logic [15:0] wire_width_q;
	logic [12:0] screen_width_q, screen_height_q;

	trr_pkg::tri_rec_t push_rec, pop_rec;
	logic push, full, pop, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_mode_q    <= trr_pkg::DRAW_FLAT;
			face_cull_q     <= trr_pkg::CULL_NONE;
			wire_width_q    <= '0;
			screen_width_q  <= 13'd512;
			screen_height_q <= 13'd512;
		end else if (cfg_valid) begin
			case (cfg_index)
				trr_pkg::CFG_SHADE_MODE:    shade_mode_q    <= cfg_data[1:0];
				trr_pkg::CFG_FACE_CULL:     face_cull_q     <= cfg_data[1:0];
				trr_pkg::CFG_WIRE_WIDTH:    wire_width_q    <= cfg_data;
				trr_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				trr_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	trr_front #(
		.TILE_SIDE  (TILE_SIDE),
		.SCREEN_MAX (SCREEN_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_data       (s_axis_tdata),
		.face_cull     (face_cull_q),
		.wire_width    (wire_width_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.push          (push),
		.full          (full),
		.rec           (push_rec)
	);

	trr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_rec),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_rec),
		.empty  (q_empty)
	);

	trr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (pop_rec),
		.q_empty     (q_empty),
		.pop         (pop),
		.shade_mode  (shade_mode_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_covered (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule

// File: rtl/trr_queue.sv
// Two-entry queue of triangle setup records between front and back.
module trr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  trr_pkg::tri_rec_t  wdata,
	output logic               full,
	input  logic               pop,
	output trr_pkg::tri_rec_t  rdata,
	output logic               empty
);

	localparam int AW = $clog2(trr_pkg::QDEPTH);

	trr_pkg::tri_rec_t mem_q [trr_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(trr_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= (wp_q == AW'(trr_pkg::QDEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop && !empty) begin
				rp_q <= (rp_q == AW'(trr_pkg::QDEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/trr_front.sv
// Triangle setup: determinant, culling, winding swap, box clip and edge start values.
module trr_front #(
	parameter int TILE_SIDE  = 8,
	parameter int SCREEN_MAX = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [trr_pkg::IN_W-1:0]   in_data,
	input  logic [1:0]                 face_cull,
	input  logic [15:0]                wire_width,
	input  logic [12:0]                screen_width,
	input  logic [12:0]                screen_height,
	output logic                       push,
	input  logic                       full,
	output trr_pkg::tri_rec_t          rec
);

	localparam int CW = trr_pkg::CW;
	localparam int DW = trr_pkg::DW;
	localparam int BW = trr_pkg::BW;
	localparam int EW = trr_pkg::EW;
	localparam int PW = trr_pkg::PW;

	trr_pkg::front_state_t state_q, state_n;

	logic signed [CW-1:0] x_q [3];
	logic signed [CW-1:0] y_q [3];
	logic [7:0] red_q, green_q, blue_q;
	logic signed [BW-1:0] tx_q, ty_q;
	logic signed [BW-1:0] lx_q, hx_q, ly_q, hy_q;
	logic [trr_pkg::DABW-1:0] dabs_q;
	logic empty_q;
	logic signed [PW-1:0] p_q [7];
	logic [2:0] k_q;

	logic signed [16:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] det;
	logic neg, drop;
	logic signed [BW-1:0] minx, maxx, miny, maxy, swv, shv, lx, hx, ly, hy, tile_hi_x, tile_hi_y;
	logic signed [DW-1:0] dxv [3];
	logic signed [DW-1:0] dyv [3];
	logic accept, setup_en, edge_en;

	function automatic logic signed [BW-1:0] bmin(input logic signed [BW-1:0] a,
		input logic signed [BW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [BW-1:0] bmax(input logic signed [BW-1:0] a,
		input logic signed [BW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	assign accept = in_valid && in_ready;

	// edge k runs from vertex k to vertex k+1 (after the winding swap)
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dxv[k] = DW'(x_q[(k + 1) % 3]) - DW'(x_q[k]);
			dyv[k] = DW'(y_q[(k + 1) % 3]) - DW'(y_q[k]);
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			trr_pkg::F_DET0: begin
				mul_a = 17'(dxv[0]);
				mul_b = 31'(DW'(y_q[2]) - DW'(y_q[0]));
			end
			trr_pkg::F_DET1: begin
				mul_a = 17'(dyv[0]);
				mul_b = 31'(DW'(x_q[2]) - DW'(x_q[0]));
			end
			trr_pkg::F_EDGE: begin
				case (k_q)
					3'd0: begin mul_a = 17'(dxv[0]); mul_b = 31'(ly_q) - 31'(y_q[0]); end
					3'd1: begin mul_a = 17'(dyv[0]); mul_b = 31'(lx_q) - 31'(x_q[0]); end
					3'd2: begin mul_a = 17'(dxv[1]); mul_b = 31'(ly_q) - 31'(y_q[1]); end
					3'd3: begin mul_a = 17'(dyv[1]); mul_b = 31'(lx_q) - 31'(x_q[1]); end
					3'd4: begin mul_a = 17'(dxv[2]); mul_b = 31'(ly_q) - 31'(y_q[2]); end
					3'd5: begin mul_a = 17'(dyv[2]); mul_b = 31'(lx_q) - 31'(x_q[2]); end
					default: begin
						mul_a = signed'({1'b0, wire_width});
						mul_b = signed'({1'b0, dabs_q});
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// setup math on the registered determinant products
	always_comb begin
		det  = p_q[0] - p_q[1];
		neg  = det[PW-1];
		drop = (det == '0)
			|| (face_cull == trr_pkg::CULL_POS && !neg)
			|| (face_cull == trr_pkg::CULL_NEG && neg);
		minx = bmin(bmin(BW'(x_q[0]), BW'(x_q[1])), BW'(x_q[2]));
		maxx = bmax(bmax(BW'(x_q[0]), BW'(x_q[1])), BW'(x_q[2]));
		miny = bmin(bmin(BW'(y_q[0]), BW'(y_q[1])), BW'(y_q[2]));
		maxy = bmax(bmax(BW'(y_q[0]), BW'(y_q[1])), BW'(y_q[2]));
		swv  = (screen_width > 13'(SCREEN_MAX)) ? BW'(SCREEN_MAX) : BW'(screen_width);
		shv  = (screen_height > 13'(SCREEN_MAX)) ? BW'(SCREEN_MAX) : BW'(screen_height);
		tile_hi_x = tx_q + BW'(TILE_SIDE);
		tile_hi_y = ty_q + BW'(TILE_SIDE);
		lx = bmax(bmax(minx, '0), tx_q);
		hx = bmin(bmin(maxx, swv), tile_hi_x);
		ly = bmax(bmax(miny, '0), ty_q);
		hy = bmin(bmin(maxy, shv), tile_hi_y);
	end

	always_comb begin
		state_n  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		setup_en = 1'b0;
		edge_en  = 1'b0;
		case (state_q)
			trr_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = trr_pkg::F_DET0;
				end
			end
			trr_pkg::F_DET0: state_n = trr_pkg::F_DET1;
			trr_pkg::F_DET1: state_n = trr_pkg::F_SETUP;
			trr_pkg::F_SETUP: begin
				setup_en = 1'b1;
				// culled or box empty: no edge values needed
				state_n = (drop || lx >= hx || ly >= hy) ? trr_pkg::F_PUSH : trr_pkg::F_EDGE;
			end
			trr_pkg::F_EDGE: begin
				edge_en = 1'b1;
				if (k_q == 3'd6) begin
					state_n = trr_pkg::F_PUSH;
				end
			end
			trr_pkg::F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_n = trr_pkg::F_IDLE;
				end
			end
			default: state_n = trr_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trr_pkg::F_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			if (setup_en) begin
				k_q <= '0;
			end else if (edge_en) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0]  <= in_data[13:0];
			y_q[0]  <= in_data[27:14];
			x_q[1]  <= in_data[41:28];
			y_q[1]  <= in_data[55:42];
			x_q[2]  <= in_data[69:56];
			y_q[2]  <= in_data[83:70];
			red_q   <= in_data[91:84];
			green_q <= in_data[99:92];
			blue_q  <= in_data[107:100];
			tx_q    <= BW'(in_data[116:108]) * BW'(TILE_SIDE);
			ty_q    <= BW'(in_data[125:117]) * BW'(TILE_SIDE);
		end
		if (state_q == trr_pkg::F_DET0) begin
			p_q[0] <= prod;
		end
		if (state_q == trr_pkg::F_DET1) begin
			p_q[1] <= prod;
		end
		if (setup_en) begin
			// put the triangle in counter-clockwise order
			if (neg) begin
				x_q[1] <= x_q[2];
				x_q[2] <= x_q[1];
				y_q[1] <= y_q[2];
				y_q[2] <= y_q[1];
			end
			dabs_q  <= neg ? trr_pkg::DABW'(-det) : trr_pkg::DABW'(det);
			lx_q    <= lx;
			hx_q    <= hx;
			ly_q    <= ly;
			hy_q    <= hy;
			empty_q <= drop || lx >= hx || ly >= hy;
		end
		if (edge_en) begin
			p_q[k_q] <= prod;
		end
	end

	always_comb begin
		rec.empty = empty_q;
		rec.dx0   = dxv[0];
		rec.dx1   = dxv[1];
		rec.dx2   = dxv[2];
		rec.dy0   = dyv[0];
		rec.dy1   = dyv[1];
		rec.dy2   = dyv[2];
		rec.e0    = EW'(p_q[0] - p_q[1]);
		rec.e1    = EW'(p_q[2] - p_q[3]);
		rec.e2    = EW'(p_q[4] - p_q[5]);
		rec.dabs  = dabs_q;
		rec.lim   = p_q[6][trr_pkg::LIMW-1:0];
		rec.lx    = lx_q;
		rec.hx    = hx_q;
		rec.ly    = ly_q;
		rec.hy    = hy_q;
		rec.red   = red_q;
		rec.green = green_q;
		rec.blue  = blue_q;
	end

endmodule

// File: rtl/trr_back.sv
// Pixel walker: edge tests, shading, fragment hold and output register.
module trr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trr_pkg::tri_rec_t           rec,
	input  logic                        q_empty,
	output logic                        pop,
	input  logic [1:0]                  shade_mode,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [trr_pkg::OUT_W-1:0]   out_data,
	output logic                        out_covered,
	output logic                        out_last
);

	localparam int BW = trr_pkg::BW;
	localparam int EW = trr_pkg::EW;
	localparam int RW = trr_pkg::RW;
	localparam int DABW = trr_pkg::DABW;

	trr_pkg::back_state_t state_q, state_n;
	trr_pkg::tri_rec_t cur_q;

	logic signed [BW-1:0] px_q, py_q, pxn, pyn;
	logic signed [EW-1:0] e_q [3];
	logic signed [EW-1:0] er_q [3];
	logic signed [EW-1:0] dxv [3];
	logic signed [EW-1:0] dyv [3];
	logic [RW-1:0] rem_q [3];
	logic [7:0]    quo_q [3];
	logic [2:0]    dcnt_q;

	logic        hold_v_q;
	logic [11:0] hold_x_q, hold_y_q;
	logic [7:0]  hold_r_q, hold_g_q, hold_b_q;

	logic        out_v_q, out_cov_q, out_last_q;
	logic [trr_pkg::OUT_W-1:0] out_data_q;

	logic in_tri, wire_skip, keep, last_x, last_pix, out_free;
	logic [2:0] far;
	logic [7:0] fr, fg, fb;
	logic load, div_start, div_step, adv, emit, finish;
	logic [RW-1:0] dsh;

	assign out_valid   = out_v_q;
	assign out_data    = out_data_q;
	assign out_covered = out_cov_q;
	assign out_last    = out_last_q;
	assign out_free    = !out_v_q || out_ready;

	always_comb begin
		dxv[0] = EW'(cur_q.dx0);
		dxv[1] = EW'(cur_q.dx1);
		dxv[2] = EW'(cur_q.dx2);
		dyv[0] = EW'(cur_q.dy0);
		dyv[1] = EW'(cur_q.dy1);
		dyv[2] = EW'(cur_q.dy2);
		for (int k = 0; k < 3; k++) begin
			far[k] = {e_q[k][EW-2:0], 16'b0} > {{(EW+15-trr_pkg::LIMW){1'b0}}, cur_q.lim};
		end
		in_tri    = !e_q[0][EW-1] && !e_q[1][EW-1] && !e_q[2][EW-1];
		wire_skip = (shade_mode == trr_pkg::DRAW_WIRE) && (&far);
		keep      = in_tri && !wire_skip;
		pxn       = px_q + BW'(1);
		pyn       = py_q + BW'(1);
		last_x    = pxn >= cur_q.hx;
		last_pix  = last_x && (pyn >= cur_q.hy);
		dsh       = {1'b0, cur_q.dabs, 7'b0};
		case (shade_mode)
			trr_pkg::DRAW_BARY: begin fr = quo_q[0]; fg = quo_q[1]; fb = quo_q[2]; end
			trr_pkg::DRAW_WIRE: begin fr = 8'd0; fg = 8'd255; fb = 8'd0; end
			default: begin fr = cur_q.red; fg = cur_q.green; fb = cur_q.blue; end
		endcase
	end

	always_comb begin
		state_n   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		div_start = 1'b0;
		div_step  = 1'b0;
		adv       = 1'b0;
		emit      = 1'b0;
		finish    = 1'b0;
		case (state_q)
			trr_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					load    = 1'b1;
					state_n = rec.empty ? trr_pkg::B_END : trr_pkg::B_EVAL;
				end
			end
			trr_pkg::B_EVAL: begin
				if (keep) begin
					if (shade_mode == trr_pkg::DRAW_BARY) begin
						div_start = 1'b1;
						state_n   = trr_pkg::B_DIV;
					end else begin
						state_n = trr_pkg::B_EMIT;
					end
				end else begin
					adv     = 1'b1;
					state_n = last_pix ? trr_pkg::B_END : trr_pkg::B_EVAL;
				end
			end
			trr_pkg::B_DIV: begin
				div_step = 1'b1;
				if (dcnt_q == 3'd0) begin
					state_n = trr_pkg::B_EMIT;
				end
			end
			trr_pkg::B_EMIT: begin
				// the previous fragment leaves when a newer one replaces it or when the triangle ends
				if (!hold_v_q || out_free) begin
					emit    = 1'b1;
					adv     = 1'b1;
					state_n = last_pix ? trr_pkg::B_END : trr_pkg::B_EVAL;
				end
			end
			trr_pkg::B_END: begin
				if (out_free) begin
					finish  = 1'b1;
					state_n = trr_pkg::B_IDLE;
				end
			end
			default: state_n = trr_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= trr_pkg::B_IDLE;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit) begin
				hold_v_q <= 1'b1;
			end else if (finish) begin
				hold_v_q <= 1'b0;
			end
			if ((emit && hold_v_q) || finish) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= rec;
			px_q  <= rec.lx;
			py_q  <= rec.ly;
			e_q[0]  <= rec.e0;
			e_q[1]  <= rec.e1;
			e_q[2]  <= rec.e2;
			er_q[0] <= rec.e0;
			er_q[1] <= rec.e1;
			er_q[2] <= rec.e2;
		end else if (adv) begin
			if (!last_x) begin
				px_q <= pxn;
				for (int k = 0; k < 3; k++) begin
					e_q[k] <= e_q[k] - dyv[k];
				end
			end else begin
				px_q <= cur_q.lx;
				py_q <= pyn;
				for (int k = 0; k < 3; k++) begin
					er_q[k] <= er_q[k] + dxv[k];
					e_q[k]  <= er_q[k] + dxv[k];
				end
			end
		end
		// lanes: red from edge 1, green from edge 2, blue from edge 0
		if (div_start) begin
			dcnt_q <= 3'd7;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= {e_q[(k + 1) % 3][DABW-1:0], 8'b0}
					- RW'(e_q[(k + 1) % 3][DABW-1:0]);
			end
		end else if (div_step) begin
			dcnt_q <= dcnt_q - 3'd1;
			for (int k = 0; k < 3; k++) begin
				if (rem_q[k] >= dsh) begin
					rem_q[k] <= RW'({rem_q[k] - dsh, 1'b0});
					quo_q[k] <= {quo_q[k][6:0], 1'b1};
				end else begin
					rem_q[k] <= {rem_q[k][RW-2:0], 1'b0};
					quo_q[k] <= {quo_q[k][6:0], 1'b0};
				end
			end
		end
		if (emit) begin
			hold_x_q <= px_q[11:0];
			hold_y_q <= py_q[11:0];
			hold_r_q <= fr;
			hold_g_q <= fg;
			hold_b_q <= fb;
		end
		if (emit && hold_v_q) begin
			out_data_q <= {hold_b_q, hold_g_q, hold_r_q, hold_y_q, hold_x_q};
			out_cov_q  <= 1'b1;
			out_last_q <= 1'b0;
		end else if (finish) begin
			out_data_q <= hold_v_q ? {hold_b_q, hold_g_q, hold_r_q, hold_y_q, hold_x_q} : '0;
			out_cov_q  <= hold_v_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

// File: rtl/trr_checker.sv
// Port-level checks for the triangle tile rasterizer, bound to the top level.
module trr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [trr_pkg::OUT_W-1:0]     m_axis_tdata,
	input logic                          m_axis_tuser,
	input logic                          m_axis_tlast
);

	logic [3:0] open_q;
	logic in_xfer, end_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign end_xfer = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	// triangles taken whose last result has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 4'(in_xfer) - 4'(end_xfer);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("empty marker not last or not zero");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> open_q != 4'd0)
		else $error("result with no open triangle");

endmodule

bind triangle_tile_rasterizer trr_checker u_trr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: tb/triangle_tile_rasterizer_tb.sv
// Self-checking testbench for the triangle tile rasterizer: directed and random triangles.
module triangle_tile_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TILE = 8;
	localparam int SMAX = 4096;

	// codes outside the defined sets
	localparam logic [1:0] DRAW_SPARE = 2'd3;
	localparam logic [1:0] CULL_SPARE = 2'd3;
	localparam logic [trr_pkg::CFG_IW-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [trr_pkg::CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [13:0] ax, ay, bx, by_, cx, cy;
		logic [7:0] red, green, blue;
		logic [8:0] tile_col, tile_row;
	} tri_t;

	typedef struct {
		logic [11:0] px, py;
		logic [7:0] red, green, blue;
		logic covered, last;
	} frag_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [trr_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [trr_pkg::OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [trr_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [trr_pkg::CFG_DW-1:0] cfg_data = '0;

	// shadow of the block's registers
	logic [1:0] shade_mode;
	logic [1:0] face_cull;
	logic [15:0] wire_width;
	logic [12:0] screen_w, screen_h;

	frag_t expected_frags[$];
	int errors = 0;
	bit no_idle = 0;

	triangle_tile_rasterizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic longint edge_fn(longint ux, longint uy, longint vx, longint vy);
		return ux * vy - uy * vx;
	endfunction

	// fragments of one triangle/tile, pushed in raster order
	task automatic predict_fragments(input tri_t t);
		longint x0, y0, x1, y1, x2, y2, tx, ty, d, sw, sh, lx, hx, ly, hy, tmp, lim;
		longint e0, e1, e2;
		int n;
		frag_t f;
		x0 = longint'(t.ax); y0 = longint'(t.ay);
		x1 = longint'(t.bx); y1 = longint'(t.by_);
		x2 = longint'(t.cx); y2 = longint'(t.cy);
		tx = longint'(t.tile_col) * TILE;
		ty = longint'(t.tile_row) * TILE;
		n = 0;
		d = edge_fn(x1 - x0, y1 - y0, x2 - x0, y2 - y0);
		if (!(d == 0 || (face_cull == trr_pkg::CULL_POS && d > 0)
			|| (face_cull == trr_pkg::CULL_NEG && d < 0))) begin
			sw = (screen_w > 13'(SMAX)) ? longint'(SMAX) : longint'(screen_w);
			sh = (screen_h > 13'(SMAX)) ? longint'(SMAX) : longint'(screen_h);
			lx = x0 < x1 ? x0 : x1; lx = lx < x2 ? lx : x2;
			lx = lx > 0 ? lx : 0; lx = lx > tx ? lx : tx;
			hx = x0 > x1 ? x0 : x1; hx = hx > x2 ? hx : x2;
			hx = hx < sw ? hx : sw; hx = hx < tx + TILE ? hx : tx + TILE;
			ly = y0 < y1 ? y0 : y1; ly = ly < y2 ? ly : y2;
			ly = ly > 0 ? ly : 0; ly = ly > ty ? ly : ty;
			hy = y0 > y1 ? y0 : y1; hy = hy > y2 ? hy : y2;
			hy = hy < sh ? hy : sh; hy = hy < ty + TILE ? hy : ty + TILE;
			if (d < 0) begin
				tmp = x1; x1 = x2; x2 = tmp;
				tmp = y1; y1 = y2; y2 = tmp;
				d = -d;
			end
			lim = longint'(wire_width) * d;
			for (longint py = ly; py < hy; py++) begin
				for (longint px = lx; px < hx; px++) begin
					e0 = edge_fn(x1 - x0, y1 - y0, px - x0, py - y0);
					e1 = edge_fn(x2 - x1, y2 - y1, px - x1, py - y1);
					e2 = edge_fn(x0 - x2, y0 - y2, px - x2, py - y2);
					if (e0 < 0 || e1 < 0 || e2 < 0)
						continue;
					f.px = px[11:0]; f.py = py[11:0];
					f.covered = 1'b1; f.last = 1'b0;
					if (shade_mode == trr_pkg::DRAW_BARY) begin
						f.red = 8'((255 * e1) / d);
						f.green = 8'((255 * e2) / d);
						f.blue = 8'((255 * e0) / d);
					end else if (shade_mode == trr_pkg::DRAW_WIRE) begin
						if (e0 * 65536 > lim && e1 * 65536 > lim && e2 * 65536 > lim)
							continue;
						f.red = 8'd0; f.green = 8'd255; f.blue = 8'd0;
					end else begin
						f.red = t.red; f.green = t.green; f.blue = t.blue;
					end
					expected_frags.push_back(f);
					n++;
				end
			end
		end
		if (n == 0) begin
			f = '{default: 0};
			expected_frags.push_back(f);
		end
		expected_frags[$].last = 1'b1;
	endtask

	task automatic send_tri(input tri_t t);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 7));
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		predict_fragments(t);
		s_axis_tdata <= {2'b0, t.tile_row, t.tile_col, t.blue, t.green, t.red,
			t.cy, t.cx, t.by_, t.bx, t.ay, t.ax};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (expected_frags.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// waits for the block to go idle before the write
	task automatic write_reg(input logic [trr_pkg::CFG_IW-1:0] idx, input logic [15:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
		case (idx)
			trr_pkg::CFG_SHADE_MODE: shade_mode = val[1:0];
			trr_pkg::CFG_FACE_CULL: face_cull = val[1:0];
			trr_pkg::CFG_WIRE_WIDTH: wire_width = val;
			trr_pkg::CFG_SCREEN_WIDTH: screen_w = val[12:0];
			trr_pkg::CFG_SCREEN_HEIGHT: screen_h = val[12:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [1:0] dm, input logic [1:0] cm, input logic [15:0] ww,
		input logic [12:0] sw, input logic [12:0] sh);
		write_reg(trr_pkg::CFG_SHADE_MODE, 16'(dm));
		write_reg(trr_pkg::CFG_FACE_CULL, 16'(cm));
		write_reg(trr_pkg::CFG_WIRE_WIDTH, ww);
		write_reg(trr_pkg::CFG_SCREEN_WIDTH, 16'(sw));
		write_reg(trr_pkg::CFG_SCREEN_HEIGHT, 16'(sh));
	endtask

	function automatic tri_t mk_tri(int ax, int ay, int bx, int by_, int cx, int cy,
		int tc, int tr, int r, int g, int b);
		tri_t t;
		t.ax = 14'(ax); t.ay = 14'(ay); t.bx = 14'(bx);
		t.by_ = 14'(by_); t.cx = 14'(cx); t.cy = 14'(cy);
		t.tile_col = 9'(tc); t.tile_row = 9'(tr);
		t.red = 8'(r); t.green = 8'(g); t.blue = 8'(b);
		return t;
	endfunction

	// mostly triangles around the tile; some fully random bit patterns
	function automatic tri_t rand_tri(int max_tile);
		tri_t t;
		int bx0, by0;
		t.red = 8'($urandom); t.green = 8'($urandom); t.blue = 8'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			t.ax = 14'($urandom); t.ay = 14'($urandom); t.bx = 14'($urandom);
			t.by_ = 14'($urandom); t.cx = 14'($urandom); t.cy = 14'($urandom);
			t.tile_col = 9'($urandom); t.tile_row = 9'($urandom);
		end else begin
			t.tile_col = 9'($urandom_range(0, max_tile));
			t.tile_row = 9'($urandom_range(0, max_tile));
			bx0 = int'(t.tile_col) * TILE;
			by0 = int'(t.tile_row) * TILE;
			t.ax = 14'(bx0 + int'($urandom_range(0, 40)) - 16);
			t.ay = 14'(by0 + int'($urandom_range(0, 40)) - 16);
			t.bx = 14'(bx0 + int'($urandom_range(0, 40)) - 16);
			t.by_ = 14'(by0 + int'($urandom_range(0, 40)) - 16);
			t.cx = 14'(bx0 + int'($urandom_range(0, 40)) - 16);
			t.cy = 14'(by0 + int'($urandom_range(0, 40)) - 16);
		end
		return t;
	endfunction

	// result side: random stalls and the field checks
	always @(posedge clk) begin : result_check
		int stall;
		frag_t e;
		logic [11:0] gx, gy;
		logic [7:0] gr, gg, gb;
		if (!arst_n) begin
			stall = 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			{gb, gg, gr, gy, gx} = m_axis_tdata;
			if (expected_frags.size() == 0) begin
				$display("%0t: mismatch expected no fragment, actual x=%0d y=%0d",
					$time, gx, gy);
				errors++;
			end else begin
				e = expected_frags.pop_front();
				if (gx !== e.px || gy !== e.py || gr !== e.red || gg !== e.green ||
					gb !== e.blue || m_axis_tuser !== e.covered || m_axis_tlast !== e.last) begin
					$display("%0t: mismatch expected x=%0d y=%0d rgb=%0d,%0d,%0d cov=%0b last=%0b",
						$time, e.px, e.py, e.red, e.green, e.blue, e.covered, e.last);
					$display("%0t:          actual x=%0d y=%0d rgb=%0d,%0d,%0d cov=%0b last=%0b",
						$time, gx, gy, gr, gg, gb, m_axis_tuser, m_axis_tlast);
					errors++;
				end
			end
			stall = no_idle ? 0 : int'($urandom_range(0, 7));
		end else if (stall > 0) begin
			stall--;
		end
		m_axis_tready <= arst_n && (stall == 0);
	end

	task automatic test_flat_defaults();
		send_tri(mk_tri(0, 0, 8, 0, 0, 8, 0, 0, 255, 0, 255));
		send_tri(mk_tri(0, 0, 0, 8, 8, 0, 0, 0, 0, 255, 0));
		send_tri(mk_tri(-4096, -4096, 8191, -4096, -4096, 8191, 3, 5, 17, 34, 51));
		send_tri(mk_tri(8191, 8191, -4096, 8191, 8191, -4096, 63, 63, 1, 2, 3));
		send_tri(mk_tri(2, 2, 6, 6, 10, 10, 0, 0, 9, 9, 9));
		send_tri(mk_tri(0, 0, 100, 0, 0, 100, 511, 511, 9, 9, 9));
		drain();
	endtask

	task automatic test_draw_modes();
		set_regs(trr_pkg::DRAW_BARY, trr_pkg::CULL_NONE, 16'd0, 13'd512, 13'd512);
		send_tri(mk_tri(-3, -2, 20, 1, 2, 19, 0, 0, 0, 0, 0));
		send_tri(mk_tri(8, 8, 8, 16, 16, 8, 1, 1, 0, 0, 0));
		set_regs(trr_pkg::DRAW_WIRE, CULL_SPARE, 16'd0, 13'd512, 13'd512);
		send_tri(mk_tri(-3, -2, 20, 1, 2, 19, 0, 0, 0, 0, 0));
		write_reg(trr_pkg::CFG_WIRE_WIDTH, 16'hFFFF);
		send_tri(mk_tri(-3, -2, 20, 1, 2, 19, 0, 0, 0, 0, 0));
		write_reg(trr_pkg::CFG_WIRE_WIDTH, 16'h1000);
		send_tri(mk_tri(0, 0, 30, 0, 0, 30, 1, 0, 0, 0, 0));
		write_reg(trr_pkg::CFG_SHADE_MODE, 16'(DRAW_SPARE));
		send_tri(mk_tri(0, 0, 30, 0, 0, 30, 1, 0, 200, 100, 50));
		drain();
	endtask

	task automatic test_culling();
		set_regs(trr_pkg::DRAW_FLAT, trr_pkg::CULL_POS, 16'd0, 13'd512, 13'd512);
		send_tri(mk_tri(0, 0, 8, 0, 0, 8, 0, 0, 1, 1, 1));
		send_tri(mk_tri(0, 0, 0, 8, 8, 0, 0, 0, 2, 2, 2));
		write_reg(trr_pkg::CFG_FACE_CULL, 16'(trr_pkg::CULL_NEG));
		send_tri(mk_tri(0, 0, 8, 0, 0, 8, 0, 0, 3, 3, 3));
		send_tri(mk_tri(0, 0, 0, 8, 8, 0, 0, 0, 4, 4, 4));
		write_reg(trr_pkg::CFG_FACE_CULL, 16'(CULL_SPARE));
		send_tri(mk_tri(0, 0, 0, 8, 8, 0, 0, 0, 5, 5, 5));
		drain();
	endtask

	task automatic test_screen_clip();
		set_regs(trr_pkg::DRAW_FLAT, trr_pkg::CULL_NONE, 16'd0, 13'd1, 13'd1);
		send_tri(mk_tri(0, 0, 8, 0, 0, 8, 0, 0, 6, 6, 6));
		set_regs(trr_pkg::DRAW_FLAT, trr_pkg::CULL_NONE, 16'd0, 13'd0, 13'd512);
		send_tri(mk_tri(0, 0, 8, 0, 0, 8, 0, 0, 7, 7, 7));
		set_regs(trr_pkg::DRAW_FLAT, trr_pkg::CULL_NONE, 16'd0, 13'h1FFF, 13'd4096);
		send_tri(mk_tri(4080, 4080, 8000, 4080, 4080, 8000, 511, 511, 8, 8, 8));
		send_tri(mk_tri(4080, 4080, 8000, 4080, 4080, 8000, 510, 510, 8, 8, 8));
		write_reg(CFG_SPARE_LO, 16'hFFFF);
		write_reg(CFG_SPARE_HI, 16'h0000);
		drain();
	endtask

	task automatic test_random();
		logic [12:0] sw, sh;
		for (int phase = 0; phase < 4; phase++) begin
			sw = (phase == 3) ? 13'($urandom_range(1, 8191)) : 13'($urandom_range(64, 4096));
			sh = (phase == 3) ? 13'($urandom_range(1, 8191)) : 13'($urandom_range(64, 4096));
			set_regs(phase % 3 == 1 ? trr_pkg::DRAW_BARY : 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 16'($urandom), sw, sh);
			no_idle = (phase == 2);
			for (int i = 0; i < 90; i++) begin
				send_tri(rand_tri(phase == 1 ? 8 : 70));
				if (phase == 0 && i == 45)
					drain();
			end
			drain();
			no_idle = 0;
		end
	endtask

	initial begin
		shade_mode = trr_pkg::DRAW_FLAT;
		face_cull = trr_pkg::CULL_NONE;
		wire_width = 16'd0;
		screen_w = 13'd512;
		screen_h = 13'd512;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_flat_defaults();
		test_draw_modes();
		test_culling();
		test_screen_clip();
		test_random();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
